### design/fed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types and constants of the feedback echo delay: register map,
// configuration and status bundles, fixed-point constants.
// ----------------------------------------------------------------------------
package fed_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register field widths.
  localparam int GAIN_W  = 16;
  localparam int DELAY_W = 16;
  localparam int COUNT_W = 2;

  // Q2.14 gains: fraction bits and the half-LSB used for rounding.
  localparam int GAIN_FRAC  = 14;
  localparam int ROUND_HALF = 8192;

  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY_GAIN      = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_DELAY_LENGTH  = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } fed_reg_t;

  // Reset values of the registers.
  localparam logic signed [GAIN_W-1:0] DRY_GAIN_RST      = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'sd0;
  localparam logic [DELAY_W-1:0]       DELAY_LENGTH_RST  = 16'd0;
  localparam logic [COUNT_W-1:0]       CHANNEL_COUNT_RST = 2'd2;

  // Configuration register bundle.
  typedef struct packed {
    logic signed [GAIN_W-1:0] dry_gain;
    logic signed [GAIN_W-1:0] feedback_gain;
    logic [DELAY_W-1:0]       delay_length;
    logic [COUNT_W-1:0]       channel_count;
  } fed_cfg_t;

  // Status of the back end.
  typedef struct packed {
    logic clearing;
    logic pipe_busy;
  } fed_stat_t;

endpackage
`default_nettype wire

### design/fed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_front
// Classifies each accepted sample: resolves its channel, computes the write
// slot and the tap slot in the echo memory, and advances the frame position.
// ----------------------------------------------------------------------------
module fed_front #(
  parameter int BUFFER_DEPTH = 65536,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 24,
  localparam int MEM_DEPTH   = BUFFER_DEPTH * CHANNELS,
  localparam int ADDR_W      = $clog2(MEM_DEPTH),
  localparam int ENTRY_W     = SAMPLE_WIDTH + 2 * ADDR_W + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fed_pkg::fed_cfg_t       cfg,
  input  wire logic                    accept,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                    in_channel,
  output logic [ENTRY_W-1:0]           item
);
  import fed_pkg::*;

  localparam int POS_W = $clog2(BUFFER_DEPTH);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int FW    = ((POS_W + 1 > DELAY_W) ? POS_W + 1 : DELAY_W) + 1;

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [CH_W-1:0]   ch;
  logic [CMP_W-1:0]  cnt_raw;
  logic [CMP_W-1:0]  cnt_eff;
  logic              last_ch;
  logic [FW-1:0]     delay_ext;
  logic [FW-1:0]     depth_ext;
  logic [FW-1:0]     d_eff;
  logic [FW-1:0]     from_sum;
  logic [POS_W-1:0]  from_pos;
  logic [ADDR_W-1:0] to_addr;
  logic [ADDR_W-1:0] from_addr;
  logic              self_tap;

  // Channel and effective channel count.
  always_comb begin
    ch      = (CHANNELS > 1) ? CH_W'(in_channel) : '0;
    cnt_raw = CMP_W'(cfg.channel_count);
    if (cnt_raw == '0) begin
      cnt_eff = CMP_W'(1);
    end else if (cnt_raw > CMP_W'(CHANNELS)) begin
      cnt_eff = CMP_W'(CHANNELS);
    end else begin
      cnt_eff = cnt_raw;
    end
    last_ch = (CMP_W'(ch) == cnt_eff - CMP_W'(1));
  end

  // Tap position: delay saturated to the depth, then wrapped once.
  always_comb begin
    delay_ext = FW'(cfg.delay_length);
    depth_ext = FW'(BUFFER_DEPTH);
    d_eff     = (delay_ext > depth_ext) ? depth_ext : delay_ext;
    from_sum  = FW'(pos_r) + depth_ext - d_eff;
    if (from_sum >= depth_ext) begin
      from_pos = POS_W'(from_sum - depth_ext);
    end else begin
      from_pos = POS_W'(from_sum);
    end
    self_tap  = (from_pos == pos_r);
    to_addr   = ADDR_W'(pos_r) * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    from_addr = ADDR_W'(from_pos) * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    item      = {self_tap, from_addr, to_addr, in_sample};
  end

  // Frame position moves on after the last channel in use.
  always_comb begin
    if (pos_r == POS_W'(BUFFER_DEPTH - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept && last_ch) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

### design/fed_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fed_queue #(
  parameter int WIDTH = 59
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);
  import fed_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### design/fed_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_back
// Echo memory and arithmetic pipeline: tap read, gain products, stored value
// with write-back, output sum, output register. Clears the memory after reset.
// ----------------------------------------------------------------------------
module fed_back #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int MEM_DEPTH    = 131072,
  localparam int ADDR_W      = $clog2(MEM_DEPTH),
  localparam int ENTRY_W     = SAMPLE_WIDTH + 2 * ADDR_W + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fed_pkg::fed_cfg_t       cfg,
  input  wire logic                    q_valid,
  input  wire logic [ENTRY_W-1:0]      q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0]      out_sample,
  output logic                         out_clip,
  output fed_pkg::fed_stat_t           stat
);
  import fed_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = SW + GAIN_W;
  localparam int SUM_W = PW + 2;
  localparam int RW    = SUM_W - GAIN_FRAC;
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  // Queue head fields.
  logic signed [SW-1:0] a_x;
  logic [ADDR_W-1:0]    a_to;
  logic [ADDR_W-1:0]    a_from;
  logic                 a_self;

  // Control.
  logic                 adv;
  logic                 hazard;
  logic                 issue;
  logic                 fwd_nxt;
  logic                 clr_r;
  logic [ADDR_W-1:0]    clr_addr_r;

  // Memory ports.
  logic [SW-1:0]        mem [MEM_DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [SW-1:0]        mem_wdata;
  logic signed [SW-1:0] rd_q;

  // Read stage.
  logic                 b_valid_r;
  logic signed [SW-1:0] b_x_r;
  logic [ADDR_W-1:0]    b_to_r;
  logic                 b_self_r;
  logic                 b_fwd_r;
  logic signed [SW-1:0] b_fwd_val_r;
  logic signed [SW-1:0] tap_b;
  logic signed [PW-1:0] p_fb_nxt;
  logic signed [PW-1:0] p_dry_nxt;

  // Write-back stage.
  logic                 c_valid_r;
  logic signed [PW-1:0] c_p_fb_r;
  logic signed [PW-1:0] c_p_dry_r;
  logic signed [SW-1:0] c_x_r;
  logic signed [SW-1:0] c_tap_r;
  logic [ADDR_W-1:0]    c_to_r;
  logic                 c_self_r;
  logic signed [SUM_W-1:0] fb_acc;
  logic signed [SUM_W-1:0] dry_acc;
  logic signed [RW-1:0] fb_q;
  logic signed [RW-1:0] dry_q;
  logic                 fb_ovf;
  logic [SW-1:0]        stored;

  // Output sum stage.
  logic                 d_valid_r;
  logic signed [RW-1:0] d_dry_r;
  logic signed [SW-1:0] d_tap_r;
  logic                 d_clip_r;
  logic signed [RW-1:0] y_sum;
  logic                 y_ovf;
  logic [SW-1:0]        y;

  // Output register.
  logic                 out_valid_r;
  logic [SW-1:0]        out_sample_r;
  logic                 out_clip_r;

  assign a_x    = q_item[SW-1:0];
  assign a_to   = q_item[SW +: ADDR_W];
  assign a_from = q_item[SW + ADDR_W +: ADDR_W];
  assign a_self = q_item[ENTRY_W-1];

  // The whole pipeline moves when the output register can take a result.
  // An item whose tap is the slot that the item in the read stage will write is held back;
  // a tap written by the write-back stage in the same cycle is forwarded.
  assign adv     = !out_valid_r || out_ready;
  assign hazard  = b_valid_r && (b_to_r == a_from);
  assign issue   = q_valid && adv && !hazard && !clr_r;
  assign fwd_nxt = c_valid_r && (c_to_r == a_from);
  assign q_pop   = issue;

  // Memory write port is shared between the clear pass and write-back.
  assign mem_we    = clr_r || (adv && c_valid_r);
  assign mem_waddr = clr_r ? clr_addr_r : c_to_r;
  assign mem_wdata = clr_r ? '0 : stored;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q <= mem[a_from];
    end
  end

  // Clear pass over every slot after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  // Gain products on the tap and on the dry input.
  always_comb begin
    tap_b     = b_fwd_r ? b_fwd_val_r : rd_q;
    p_fb_nxt  = PW'(tap_b) * PW'(cfg.feedback_gain);
    p_dry_nxt = PW'(b_x_r) * PW'(cfg.dry_gain);
  end

  // Stored value: input plus rounded feedback product, saturated.
  always_comb begin
    fb_acc  = SUM_W'(c_p_fb_r) + (SUM_W'(c_x_r) <<< GAIN_FRAC) + SUM_W'(ROUND_HALF);
    fb_q    = fb_acc[SUM_W-1:GAIN_FRAC];
    fb_ovf  = (fb_q[RW-1:SW-1] != {(RW-SW+1){fb_q[RW-1]}});
    stored  = fb_ovf ? (fb_q[RW-1] ? SAT_MIN : SAT_MAX) : fb_q[SW-1:0];
    dry_acc = SUM_W'(c_p_dry_r) + SUM_W'(ROUND_HALF);
    dry_q   = dry_acc[SUM_W-1:GAIN_FRAC];
  end

  // Output: rounded dry product plus tap, saturated.
  always_comb begin
    y_sum = d_dry_r + RW'(d_tap_r);
    y_ovf = (y_sum[RW-1:SW-1] != {(RW-SW+1){y_sum[RW-1]}});
    y     = y_ovf ? (y_sum[RW-1] ? SAT_MIN : SAT_MAX) : y_sum[SW-1:0];
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r   <= issue;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (issue) begin
      b_x_r       <= a_x;
      b_to_r      <= a_to;
      b_self_r    <= a_self;
      b_fwd_r     <= fwd_nxt;
      b_fwd_val_r <= stored;
    end
    if (adv) begin
      c_p_fb_r     <= p_fb_nxt;
      c_p_dry_r    <= p_dry_nxt;
      c_x_r        <= b_x_r;
      c_tap_r      <= tap_b;
      c_to_r       <= b_to_r;
      c_self_r     <= b_self_r;
      d_dry_r      <= dry_q;
      d_tap_r      <= c_self_r ? stored : c_tap_r;
      d_clip_r     <= fb_ovf;
      out_sample_r <= y;
      out_clip_r   <= d_clip_r | y_ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_clip       = out_clip_r;
  assign stat.clearing  = clr_r;
  assign stat.pipe_busy = b_valid_r || c_valid_r || d_valid_r;

endmodule
`default_nettype wire

### design/feedback_echo_delay_top.sv
`default_nettype none
// Path: queue, read stage, write-back stage, output sum stage, output register.
// Throughput: one sample per cycle while out_tready keeps the output moving; a sample
// whose tap slot is written by the sample just ahead of it waits, since that write
// lands in the write-back stage. Reset: synchronous, active low; then the echo memory
// is cleared one slot a cycle over BUFFER_DEPTH*CHANNELS (131072) slots, in_tready low.
// ----------------------------------------------------------------------------
// feedback_echo_delay_top
// Feedback echo on interleaved audio: a front stage classifies samples, a
// short queue decouples it from the memory and arithmetic pipeline.
// ----------------------------------------------------------------------------
module feedback_echo_delay_top #(
  parameter int BUFFER_DEPTH = 65536,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 24,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [TDATA_W-1:0]               in_tdata,   // [SW-1:0] sample_in
  input  wire logic                             in_tuser,   // [0] channel
  // Result stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [TDATA_W-1:0]                    out_tdata,  // [SW-1:0] sample_out
  output logic                                  out_tuser,  // [0] clipped
  // Configuration writes.
  input  wire logic                             cfg_we,
  input  wire logic [fed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fed_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fed_pkg::*;

  localparam int MEM_DEPTH = BUFFER_DEPTH * CHANNELS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ENTRY_W   = SAMPLE_WIDTH + 2 * ADDR_W + 1;

  fed_cfg_t                cfg_r;
  fed_stat_t               stat;
  logic                    in_xfer;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic [ENTRY_W-1:0]      front_item;
  logic [ENTRY_W-1:0]      q_item;
  logic [SAMPLE_WIDTH-1:0] out_sample;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_gain      <= DRY_GAIN_RST;
      cfg_r.feedback_gain <= FEEDBACK_GAIN_RST;
      cfg_r.delay_length  <= DELAY_LENGTH_RST;
      cfg_r.channel_count <= CHANNEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (fed_reg_t'(cfg_index))
        REG_DRY_GAIN:      cfg_r.dry_gain      <= cfg_wdata;
        REG_FEEDBACK_GAIN: cfg_r.feedback_gain <= cfg_wdata;
        REG_DELAY_LENGTH:  cfg_r.delay_length  <= cfg_wdata;
        REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer: blocked during the clear pass or when the queue is full.
  assign in_tready = !stat.clearing && !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  fed_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (in_xfer),
    .in_sample  (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_channel (in_tuser),
    .item       (front_item)
  );

  fed_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_item)
  );

  fed_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MEM_DEPTH    (MEM_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_clip   (out_tuser),
    .stat       (stat)
  );

  assign out_tdata = TDATA_W'(out_sample);

`ifndef SYNTHESIS
  // No sample is taken while the memory is being cleared.
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_xfer)
    else $error("input transfer during clear pass");

  // A transferred sample is waiting in the queue on the next cycle.
  a_xfer_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> q_valid)
    else $error("transferred sample missing from queue");

  // A new result only comes out of a busy pipeline.
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stat.pipe_busy))
    else $error("result without an item in the pipeline");
`endif

endmodule
`default_nettype wire
